// ===== rtl/ess_pkg.sv =====
// Package for the eye scan sweep sequencer.
// Holds item and result types, codes, constants and the plot character table.
// No dependencies.
package ess_pkg;

  localparam int unsigned H_STEPS_DEF = 32;
  localparam int unsigned V_RANGE_DEF = 128;
  localparam int unsigned V_STEPS_DEF = 16;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [16:0] FULL_SCALE  = 17'd131070;
  localparam logic [31:0] TIMEOUT_RST = 32'd20000000;
  localparam logic [3:0]  STATUS_OK   = 4'd5;
  localparam logic [6:0]  VMAG_CAP    = 7'd127;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_POLL   = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;
  localparam logic [1:0] KIND_RSVD   = 2'd3;

  localparam logic [1:0] FMT_ART   = 2'd0;
  localparam logic [1:0] FMT_NUM   = 2'd1;
  localparam logic [1:0] FMT_RAW   = 2'd2;
  localparam logic [1:0] FMT_SPARE = 2'd3;

  localparam logic CFG_PLOT_FORMAT = 1'b0;
  localparam logic CFG_TIMEOUT     = 1'b1;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_AT    = 7'h40;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A     = 7'h41;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  rate_div;
    logic [3:0]  scan_status;
    logic [15:0] error_count;
    logic [31:0] now_us;
  } item_t;

  typedef struct packed {
    logic [1:0]  plot_format;
    logic [31:0] timeout_us;
  } cfg_t;

  typedef struct packed {
    logic        active;
    logic        start_acq;
    logic [8:0]  vert_code;
    logic [11:0] horz_code;
    logic        stop_run;
    logic        cell_valid;
    logic [16:0] cell_count;
    logic [6:0]  cell_char;
    logic        row_end;
    logic        scan_done;
    logic        scan_failed;
  } res_t;

  // Floor of log2 for a nonzero count.
  function automatic logic [4:0] log2_floor(input logic [16:0] v);
    logic [4:0] lg;
    lg = 5'd0;
    for (int i = 1; i < 17; i++) begin
      if (v[i]) lg = 5'(i);
    end
    return lg;
  endfunction

  // Art shade for a log2 value, from the shade ramp " .:-=?*#%@".
  function automatic logic [6:0] art_char(input logic [4:0] lg);
    logic [6:0] c;
    case (lg)
      5'd0, 5'd1, 5'd2:  c = 7'h2E; // '.'
      5'd3, 5'd4:        c = 7'h3A; // ':'
      5'd5, 5'd6:        c = 7'h2D; // '-'
      5'd7, 5'd8:        c = 7'h3D; // '='
      5'd9, 5'd10, 5'd11: c = 7'h3F; // '?'
      5'd12, 5'd13:      c = 7'h2A; // '*'
      5'd14, 5'd15:      c = 7'h23; // '#'
      default:           c = 7'h25; // '%'
    endcase
    return c;
  endfunction

  function automatic logic [6:0] shade_of(input logic [16:0] count, input logic [1:0] fmt);
    logic [4:0] lg;
    logic [6:0] c;
    lg = log2_floor(count);
    if (count == 17'd0) begin
      c = CH_SPACE;
    end else if (count >= FULL_SCALE) begin
      c = CH_AT;
    end else if (fmt == FMT_NUM) begin
      c = (lg <= 5'd9) ? 7'(CH_ZERO + 7'(lg)) : 7'(CH_A + 7'(lg) - 7'd10);
    end else begin
      c = art_char(lg);
    end
    return c;
  endfunction

endpackage

// ===== rtl/ess_cfg_regs.sv =====
// Configuration registers of the eye scan sweep sequencer.
// Depends on ess_pkg.
module ess_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [ess_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ess_pkg::cfg_t                  cfg
);
  import ess_pkg::*;

  logic [1:0]  plot_format_r;
  logic [31:0] timeout_us_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plot_format_r <= FMT_ART;
      timeout_us_r  <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PLOT_FORMAT: plot_format_r <= cfg_wdata[1:0];
        CFG_TIMEOUT:     timeout_us_r  <= cfg_wdata[31:0];
        default:         ;
      endcase
    end
  end

  assign cfg.plot_format = plot_format_r;
  assign cfg.timeout_us  = timeout_us_r;

endmodule

// ===== rtl/ess_in_reg.sv =====
// Input register stage: captures and unpacks one item.
// Depends on ess_pkg.
module ess_in_reg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ess_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [1:0]                     in_tuser,
  input  logic                           take,
  output logic                           item_valid,
  output ess_pkg::item_t                 item
);
  import ess_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_tready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.kind        <= in_tuser;
      item_r.rate_div    <= in_tdata[2:0];
      item_r.scan_status <= in_tdata[6:3];
      item_r.error_count <= in_tdata[22:7];
      item_r.now_us      <= in_tdata[54:23];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/ess_engine.sv =====
// Scan state and the combinational update that turns one item into one result.
// Depends on ess_pkg.
module ess_engine #(
  parameter int unsigned H_STEPS = ess_pkg::H_STEPS_DEF,
  parameter int unsigned V_RANGE = ess_pkg::V_RANGE_DEF,
  parameter int unsigned V_STEPS = ess_pkg::V_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  ess_pkg::item_t item,
  input  ess_pkg::cfg_t  cfg,
  output ess_pkg::res_t  res
);
  import ess_pkg::*;

  localparam logic signed [8:0] V_HI     = 9'(V_RANGE);
  localparam logic signed [8:0] V_LO     = 9'(-int'(V_RANGE));
  localparam logic signed [8:0] V_STRIDE = 9'(V_RANGE / V_STEPS);

  localparam logic [12:0] STRIDE_RAW [8] = '{
    13'((32 << 0) / H_STEPS), 13'((32 << 1) / H_STEPS),
    13'((32 << 2) / H_STEPS), 13'((32 << 3) / H_STEPS),
    13'((32 << 4) / H_STEPS), 13'((32 << 5) / H_STEPS),
    13'((32 << 6) / H_STEPS), 13'((32 << 7) / H_STEPS)
  };

  logic               running_r,   running_nxt;
  logic               acquiring_r, acquiring_nxt;
  logic               ut_phase_r,  ut_phase_nxt;
  logic [2:0]         div_shift_r, div_shift_nxt;
  logic signed [13:0] horiz_r,     horiz_nxt;
  logic signed [8:0]  vert_r,      vert_nxt;
  logic [16:0]        err_sum_r,   err_sum_nxt;
  logic [31:0]        acq_t0_r,    acq_t0_nxt;

  logic signed [13:0] h_range;
  logic signed [13:0] h_stride;
  logic signed [13:0] horiz_step;
  logic [31:0]        elapsed;
  logic [16:0]        sum_now;
  logic [8:0]         vabs;
  logic [6:0]         vmag;
  logic               vneg;

  always_comb begin
    h_range    = {1'b0, 13'(13'd32 << div_shift_r)};
    h_stride   = (STRIDE_RAW[div_shift_r] == 13'd0) ? 14'sd1 : {1'b0, STRIDE_RAW[div_shift_r]};
    horiz_step = horiz_r + h_stride;
    elapsed    = item.now_us - acq_t0_r;
    sum_now    = err_sum_r + 17'(item.error_count);
    vneg       = vert_r < 9'sd0;
    vabs       = vneg ? 9'(-vert_r) : 9'(vert_r);
    vmag       = (vabs > 9'(VMAG_CAP)) ? VMAG_CAP : vabs[6:0];
  end

  always_comb begin
    running_nxt   = running_r;
    acquiring_nxt = acquiring_r;
    ut_phase_nxt  = ut_phase_r;
    div_shift_nxt = div_shift_r;
    horiz_nxt     = horiz_r;
    vert_nxt      = vert_r;
    err_sum_nxt   = err_sum_r;
    acq_t0_nxt    = acq_t0_r;
    res           = '0;

    if (item.kind == KIND_START && !running_r) begin
      div_shift_nxt = item.rate_div;
      horiz_nxt     = -{1'b0, 13'(13'd32 << item.rate_div)};
      vert_nxt      = V_HI;
      ut_phase_nxt  = 1'b0;
      err_sum_nxt   = 17'd0;
      acquiring_nxt = 1'b0;
      running_nxt   = 1'b1;
    end else if (item.kind == KIND_RSVD || !running_r) begin
      running_nxt = running_r;
    end else if (item.kind == KIND_CANCEL) begin
      res.stop_run = 1'b1;
      running_nxt  = 1'b0;
    end else if (acquiring_r) begin
      if (item.scan_status[0] || elapsed > cfg.timeout_us) begin
        res.stop_run  = 1'b1;
        acquiring_nxt = 1'b0;
        if (item.scan_status == STATUS_OK) begin
          err_sum_nxt  = sum_now;
          ut_phase_nxt = !ut_phase_r;
          if (ut_phase_r) begin
            res.cell_valid = 1'b1;
            res.cell_count = sum_now;
            if (cfg.plot_format == FMT_RAW) begin
              res.cell_char = 7'd0;
            end else if (sum_now == 17'd0 && horiz_r == 14'sd0 && vert_r == 9'sd0) begin
              res.cell_char = CH_PLUS;
            end else begin
              res.cell_char = shade_of(sum_now, cfg.plot_format);
            end
            err_sum_nxt = 17'd0;
            horiz_nxt   = horiz_step;
            if (horiz_step > h_range) begin
              res.row_end = 1'b1;
              horiz_nxt   = -h_range;
              vert_nxt    = vert_r - V_STRIDE;
            end
          end
        end else begin
          res.scan_failed = 1'b1;
          running_nxt     = 1'b0;
        end
      end
    end else if (vert_r < V_LO) begin
      res.scan_done = 1'b1;
      running_nxt   = 1'b0;
    end else begin
      res.vert_code = {ut_phase_r, vneg, vmag};
      res.horz_code = horiz_r[11:0];
      res.start_acq = 1'b1;
      acq_t0_nxt    = item.now_us;
      acquiring_nxt = 1'b1;
    end

    res.active = running_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      acquiring_r <= 1'b0;
      ut_phase_r  <= 1'b0;
      div_shift_r <= 3'd0;
      horiz_r     <= 14'sd0;
      vert_r      <= 9'sd0;
      err_sum_r   <= 17'd0;
      acq_t0_r    <= 32'd0;
    end else if (fire) begin
      running_r   <= running_nxt;
      acquiring_r <= acquiring_nxt;
      ut_phase_r  <= ut_phase_nxt;
      div_shift_r <= div_shift_nxt;
      horiz_r     <= horiz_nxt;
      vert_r      <= vert_nxt;
      err_sum_r   <= err_sum_nxt;
      acq_t0_r    <= acq_t0_nxt;
    end
  end

endmodule

// ===== rtl/eye_scan_sweep_sequencer.sv =====
// Top level of the eye scan sweep sequencer.
// Depends on ess_pkg, ess_cfg_regs, ess_in_reg and ess_engine.
//
// Usage: each input item is a start, poll or cancel event (in_tuser holds the
// kind). Every accepted item gives exactly one result item on the out_ side,
// which says whether to launch an acquisition (with its offset codes) or stop
// the engine, and reports finished eye cells, the end of a row (out_tlast),
// normal completion or failure.
// Each accepted item passes one input register and one result register
// with the scan state updated in between, so out_tvalid is registered.
// Throughput is one item per cycle while the receiver keeps out_tready high;
// the state update is a single pass of short logic, so items need no gap.
// A stalled receiver holds the result register; the input register keeps
// accepting until it is full, after which in_tready drops until the result
// is taken. Reset clears the scan state and both valid flags and loads the
// register defaults (art plot format, timeout 20000000 us). Configuration
// writes on cfg_we/cfg_addr/cfg_wdata take effect at the next edge.
module eye_scan_sweep_sequencer #(
  parameter int unsigned H_STEPS = ess_pkg::H_STEPS_DEF,
  parameter int unsigned V_RANGE = ess_pkg::V_RANGE_DEF,
  parameter int unsigned V_STEPS = ess_pkg::V_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // rate_div[2:0], scan_status[6:3], error_count[22:7], now_us[54:23], zero[55]
  input  logic [ess_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // active[0], start_acq[1], vert_code[10:2], horz_code[22:11], stop_run[23],
  // cell_valid[24], cell_count[41:25], cell_char[48:42], scan_done[49],
  // scan_failed[50], zero[55:51]
  output logic [ess_pkg::OUT_TDATA_W-1:0] out_tdata,
  // row_end
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic                            cfg_addr,
  input  logic [ess_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ess_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  res;
  res_t  res_r;
  logic  item_valid;
  logic  out_valid_r;
  logic  fire;

  assign fire = item_valid && (!out_valid_r || out_tready);

  ess_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ess_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  ess_engine #(
    .H_STEPS (H_STEPS),
    .V_RANGE (V_RANGE),
    .V_STEPS (V_STEPS)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.row_end;
  assign out_tdata  = {5'd0, res_r.scan_failed, res_r.scan_done, res_r.cell_char,
                       res_r.cell_count, res_r.cell_valid, res_r.stop_run,
                       res_r.horz_code, res_r.vert_code, res_r.start_acq,
                       res_r.active};

endmodule
